// ===== hw/rtl/ctse_pkg.sv =====
// ----------------------------------------------------------------------------
// ctse_pkg: shared types and constants of the clock time-setting editor
// Key codes, editor modes, commit events, field positions, range limits and
// the month-length lookup.
// ----------------------------------------------------------------------------
package ctse_pkg;

  // Key events
  typedef enum logic [2:0] {
    KEY_NONE   = 3'd0,
    KEY_MODE   = 3'd1,
    KEY_NEXT   = 3'd2,
    KEY_UP     = 3'd3,
    KEY_DOWN   = 3'd4,
    KEY_COMMIT = 3'd5,
    KEY_ALARM  = 3'd6
  } key_e;

  // Editor mode, one-hot
  typedef enum logic [2:0] {
    MODE_SHOW      = 3'b001,
    MODE_SET_TIME  = 3'b010,
    MODE_SET_ALARM = 3'b100
  } mode_e;

  // Mode as shown on the result port
  localparam logic [1:0] MODE_CODE_SHOW  = 2'd0;
  localparam logic [1:0] MODE_CODE_TIME  = 2'd1;
  localparam logic [1:0] MODE_CODE_ALARM = 2'd2;

  // Commit events
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_TIME  = 2'd1,
    EV_ALARM = 2'd2
  } event_e;

  // Cursor positions in the edit buffer
  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;
  localparam logic [2:0] FLD_SECOND = 3'd5;
  localparam logic [2:0] FLD_WDAY   = 3'd6;

  // Field tops
  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [4:0] DAY_MAX    = 5'd31;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [2:0] WDAY_MAX   = 3'd7;

  // Days in a month; zero for a month outside 1..12
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Mode to its port code
  function automatic logic [1:0] mode_code(input mode_e mode);
    logic [1:0] code;
    unique case (mode)
      MODE_SET_TIME:  code = MODE_CODE_TIME;
      MODE_SET_ALARM: code = MODE_CODE_ALARM;
      default:        code = MODE_CODE_SHOW;
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/clock_time_setting_editor_unit.sv =====
// ----------------------------------------------------------------------------
// clock_time_setting_editor_unit: key-driven clock and alarm editor
// Applies one key event per word to the editor state and reports the mode,
// cursor, edit buffer, commit event and alarm enable after that key.
// ----------------------------------------------------------------------------
// The unit takes one key word per clock while the result port does not stall
// and returns one result word per key. While a word sits in the input
// register, its key is applied to the editor state by combinational logic.
// The updated state is registered once the result slot is free and shown on
// the result port from then on. The state update loop closes through the
// state registers alone, which sets the throughput at one key per clock when
// the result port does not stall. The buffer fields are driven straight from
// the state registers, which hold still while a result is stalled.
module clock_time_setting_editor_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] key_code_i,
  input  logic [6:0] live_year_i,
  input  logic [3:0] live_month_i,
  input  logic [4:0] live_day_i,
  input  logic [4:0] live_hour_i,
  input  logic [5:0] live_minute_i,
  input  logic [5:0] live_second_i,
  input  logic [2:0] live_weekday_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] mode_o,
  output logic [2:0] cursor_o,
  output logic [6:0] edit_year_o,
  output logic [3:0] edit_month_o,
  output logic [4:0] edit_day_o,
  output logic [4:0] edit_hour_o,
  output logic [5:0] edit_minute_o,
  output logic [5:0] edit_second_o,
  output logic [2:0] edit_weekday_o,
  output logic [1:0] event_res_o,
  output logic       alarm_on_o
);
  import ctse_pkg::*;

  // Input register
  logic       in_vld_q;
  logic [2:0] key_q;
  logic [6:0] lyear_q;
  logic [3:0] lmonth_q;
  logic [4:0] lday_q;
  logic [4:0] lhour_q;
  logic [5:0] lminute_q;
  logic [5:0] lsecond_q;
  logic [2:0] lwday_q;

  // Editor state (day keeps seven bits: it can run past 31 with no valid month)
  mode_e      mode_q, mode_d;
  logic [2:0] tcur_q, tcur_d;
  logic       acur_q, acur_d;
  logic [6:0] year_q, year_d;
  logic [3:0] month_q, month_d;
  logic [6:0] day_q, day_d;
  logic [4:0] hour_q, hour_d;
  logic [5:0] minute_q, minute_d;
  logic [5:0] second_q, second_d;
  logic [2:0] wday_q, wday_d;
  logic       alarm_q, alarm_d;
  event_e     event_q, event_d;
  logic       out_vld_q;

  logic res_free;
  logic adv;

  // Handshake
  assign res_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && res_free;
  assign in_stall_o = in_vld_q && !res_free;

  // Field selects in set-time mode
  logic s_year, s_month, s_day, s_hour, s_minute, s_second, s_wday;
  assign s_year   = (tcur_q == FLD_YEAR);
  assign s_month  = (tcur_q == FLD_MONTH);
  assign s_day    = (tcur_q == FLD_DAY);
  assign s_hour   = (tcur_q == FLD_HOUR);
  assign s_minute = (tcur_q == FLD_MINUTE);
  assign s_second = (tcur_q == FLD_SECOND);
  assign s_wday   = (tcur_q == FLD_WDAY);

  // Increment in set-time mode, then wrap every field
  logic [7:0] up_year_s;
  logic [4:0] up_month_s;
  logic [7:0] up_day_s;
  logic [5:0] up_hour_s;
  logic [6:0] up_minute_s, up_second_s;
  logic [3:0] up_wday_s;
  logic [6:0] up_year;
  logic [3:0] up_month;
  logic [4:0] up_len;
  logic [6:0] up_day;
  logic [4:0] up_hour;
  logic [5:0] up_minute, up_second;
  logic [2:0] up_wday;

  always_comb begin
    up_year_s   = {1'b0, year_q} + {7'd0, s_year};
    up_month_s  = {1'b0, month_q} + {4'd0, s_month};
    up_day_s    = {1'b0, day_q} + {7'd0, s_day};
    up_hour_s   = {1'b0, hour_q} + {5'd0, s_hour};
    up_minute_s = {1'b0, minute_q} + {6'd0, s_minute};
    up_second_s = {1'b0, second_q} + {6'd0, s_second};
    up_wday_s   = {1'b0, wday_q} + {3'd0, s_wday};

    up_year   = (up_year_s > {1'b0, YEAR_MAX}) ? 7'd0 : up_year_s[6:0];
    up_month  = (up_month_s > {1'b0, MONTH_MAX}) ? 4'd1 : up_month_s[3:0];
    up_len    = month_len(up_month, (up_year[1:0] == 2'd0));
    // Day wraps before the seven-bit mask
    up_day    = ((up_len != 5'd0) && (up_day_s > {3'd0, up_len})) ? 7'd1 : up_day_s[6:0];
    up_hour   = (up_hour_s > {1'b0, HOUR_MAX}) ? 5'd0 : up_hour_s[4:0];
    up_minute = (up_minute_s > {1'b0, MINUTE_MAX}) ? 6'd0 : up_minute_s[5:0];
    up_second = (up_second_s > {1'b0, MINUTE_MAX}) ? 6'd0 : up_second_s[5:0];
    up_wday   = (up_wday_s > {1'b0, WDAY_MAX}) ? 3'd1 : up_wday_s[2:0];
  end

  // Decrement in set-time mode, then wrap month, day and weekday
  logic [6:0] dn_year;
  logic [3:0] dn_month;
  logic       dn_under;
  logic [6:0] dn_day0;
  logic [4:0] dn_len;
  logic [6:0] dn_day;
  logic [4:0] dn_hour;
  logic [5:0] dn_minute, dn_second;
  logic [2:0] dn_wday;

  always_comb begin
    dn_year = year_q;
    if (s_year) begin
      dn_year = (year_q == 7'd0) ? YEAR_MAX : year_q - 7'd1;
    end
    dn_month = month_q;
    if (s_month && month_q != 4'd0) begin
      dn_month = month_q - 4'd1;
    end
    if (dn_month == 4'd0) begin
      dn_month = MONTH_MAX;
    end
    dn_under = s_day && (day_q == 7'd0);
    dn_day0  = (s_day && day_q != 7'd0) ? day_q - 7'd1 : day_q;
    dn_len   = month_len(dn_month, (dn_year[1:0] == 2'd0));
    // Underflow takes the month length, or 31 with no valid month
    if (dn_under) begin
      dn_day = (dn_len != 5'd0) ? {2'd0, dn_len} : {2'd0, DAY_MAX};
    end else if (dn_len == 5'd0) begin
      dn_day = dn_day0;
    end else if (dn_day0 == 7'd0) begin
      dn_day = {2'd0, dn_len};
    end else if (dn_day0 > {2'd0, dn_len}) begin
      dn_day = 7'd1;
    end else begin
      dn_day = dn_day0;
    end
    dn_hour = hour_q;
    if (s_hour) begin
      dn_hour = (hour_q == 5'd0) ? HOUR_MAX : hour_q - 5'd1;
    end
    dn_minute = minute_q;
    if (s_minute) begin
      dn_minute = (minute_q == 6'd0) ? MINUTE_MAX : minute_q - 6'd1;
    end
    dn_second = second_q;
    if (s_second) begin
      dn_second = (second_q == 6'd0) ? MINUTE_MAX : second_q - 6'd1;
    end
    dn_wday = wday_q;
    if (s_wday && wday_q != 3'd0) begin
      dn_wday = wday_q - 3'd1;
    end
    if (dn_wday == 3'd0) begin
      dn_wday = WDAY_MAX;
    end
  end

  // Alarm edits touch hour and minute only
  logic [5:0] al_hour_s;
  logic [6:0] al_minute_s;
  logic [4:0] al_up_hour, al_dn_hour;
  logic [5:0] al_up_minute, al_dn_minute;

  always_comb begin
    al_hour_s    = {1'b0, hour_q} + {5'd0, !acur_q};
    al_minute_s  = {1'b0, minute_q} + {6'd0, acur_q};
    al_up_hour   = (al_hour_s > {1'b0, HOUR_MAX}) ? 5'd0 : al_hour_s[4:0];
    al_up_minute = (al_minute_s > {1'b0, MINUTE_MAX}) ? 6'd0 : al_minute_s[5:0];
    al_dn_hour   = hour_q;
    al_dn_minute = minute_q;
    if (!acur_q) begin
      al_dn_hour = (hour_q == 5'd0) ? HOUR_MAX : hour_q - 5'd1;
    end else begin
      al_dn_minute = (minute_q == 6'd0) ? MINUTE_MAX : minute_q - 6'd1;
    end
  end

  // Apply the key to the editor state
  always_comb begin
    mode_d   = mode_q;
    tcur_d   = tcur_q;
    acur_d   = acur_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    wday_d   = wday_q;
    alarm_d  = alarm_q;
    event_d  = EV_NONE;
    unique case (key_q)
      KEY_MODE: begin
        unique case (mode_q)
          MODE_SHOW: begin
            year_d   = lyear_q;
            month_d  = lmonth_q;
            day_d    = {2'd0, lday_q};
            hour_d   = lhour_q;
            minute_d = lminute_q;
            second_d = lsecond_q;
            wday_d   = lwday_q;
            tcur_d   = FLD_YEAR;
            mode_d   = MODE_SET_TIME;
          end
          MODE_SET_TIME:  mode_d = MODE_SET_ALARM;
          MODE_SET_ALARM: mode_d = MODE_SHOW;
          default:        mode_d = MODE_SHOW;
        endcase
      end
      KEY_COMMIT: begin
        if (mode_q == MODE_SET_TIME) begin
          event_d = EV_TIME;
        end else if (mode_q == MODE_SET_ALARM) begin
          event_d = EV_ALARM;
          mode_d  = MODE_SHOW;
        end
      end
      KEY_ALARM: alarm_d = !alarm_q;
      KEY_NEXT: begin
        if (mode_q == MODE_SET_TIME) begin
          tcur_d = (tcur_q == FLD_WDAY) ? FLD_YEAR : tcur_q + 3'd1;
        end else if (mode_q == MODE_SET_ALARM) begin
          acur_d = !acur_q;
        end
      end
      KEY_UP: begin
        if (mode_q == MODE_SET_TIME) begin
          year_d   = up_year;
          month_d  = up_month;
          day_d    = up_day;
          hour_d   = up_hour;
          minute_d = up_minute;
          second_d = up_second;
          wday_d   = up_wday;
        end else if (mode_q == MODE_SET_ALARM) begin
          hour_d   = al_up_hour;
          minute_d = al_up_minute;
        end
      end
      KEY_DOWN: begin
        if (mode_q == MODE_SET_TIME) begin
          year_d   = dn_year;
          month_d  = dn_month;
          day_d    = dn_day;
          hour_d   = dn_hour;
          minute_d = dn_minute;
          second_d = dn_second;
          wday_d   = dn_wday;
        end else if (mode_q == MODE_SET_ALARM) begin
          hour_d   = al_dn_hour;
          minute_d = al_dn_minute;
        end
      end
      default: ;
    endcase
  end

  // Control and editor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_SHOW;
      tcur_q    <= FLD_YEAR;
      acur_q    <= 1'b0;
      year_q    <= '0;
      month_q   <= '0;
      day_q     <= '0;
      hour_q    <= '0;
      minute_q  <= '0;
      second_q  <= '0;
      wday_q    <= '0;
      alarm_q   <= 1'b0;
      event_q   <= EV_NONE;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (res_free) begin
        out_vld_q <= in_vld_q;
      end
      // Advance the state with the result slot
      if (adv) begin
        mode_q   <= mode_d;
        tcur_q   <= tcur_d;
        acur_q   <= acur_d;
        year_q   <= year_d;
        month_q  <= month_d;
        day_q    <= day_d;
        hour_q   <= hour_d;
        minute_q <= minute_d;
        second_q <= second_d;
        wday_q   <= wday_d;
        alarm_q  <= alarm_d;
        event_q  <= event_d;
      end
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      key_q     <= key_code_i;
      lyear_q   <= live_year_i;
      lmonth_q  <= live_month_i;
      lday_q    <= live_day_i;
      lhour_q   <= live_hour_i;
      lminute_q <= live_minute_i;
      lsecond_q <= live_second_i;
      lwday_q   <= live_weekday_i;
    end
  end

  // Result word
  assign out_valid_o    = out_vld_q;
  assign mode_o         = mode_code(mode_q);
  assign cursor_o       = (mode_q == MODE_SET_ALARM) ? (acur_q ? FLD_MINUTE : FLD_HOUR)
                                                     : tcur_q;
  assign edit_year_o    = year_q;
  assign edit_month_o   = month_q;
  assign edit_day_o     = day_q[4:0];
  assign edit_hour_o    = hour_q;
  assign edit_minute_o  = minute_q;
  assign edit_second_o  = second_q;
  assign edit_weekday_o = wday_q;
  assign event_res_o    = event_q;
  assign alarm_on_o     = alarm_q;

endmodule

// ===== hw/rtl/ctse_checker.sv =====
// ----------------------------------------------------------------------------
// ctse_checker: port-level checks of the clock time-setting editor
// Watches the result port for mode, cursor and commit consistency and for a
// stalled word that holds.
// ----------------------------------------------------------------------------
module ctse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] mode_o,
  input logic [2:0] cursor_o,
  input logic [4:0] edit_day_o,
  input logic [4:0] edit_hour_o,
  input logic [5:0] edit_minute_o,
  input logic [1:0] event_res_o
);
  import ctse_pkg::*;

  // Alarm commit drops back to show mode
  a_alarm_commit_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EV_ALARM |-> mode_o == MODE_CODE_SHOW)
    else $error("alarm commit without return to show mode");

  // Time commit only from set-time mode
  a_time_commit_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EV_TIME |-> mode_o == MODE_CODE_TIME)
    else $error("time commit outside set-time mode");

  // Alarm cursor sits on hour or minute
  a_alarm_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o == MODE_CODE_ALARM |->
      cursor_o == FLD_HOUR || cursor_o == FLD_MINUTE)
    else $error("alarm cursor off hour and minute");

  // Stalled word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_o) && $stable(cursor_o)
      && $stable(edit_day_o) && $stable(edit_hour_o) && $stable(edit_minute_o)
      && $stable(event_res_o))
    else $error("stalled result word changed");

endmodule

bind clock_time_setting_editor_unit ctse_checker u_ctse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .mode_o        (mode_o),
  .cursor_o      (cursor_o),
  .edit_day_o    (edit_day_o),
  .edit_hour_o   (edit_hour_o),
  .edit_minute_o (edit_minute_o),
  .event_res_o   (event_res_o)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the clock time-setting editor
// Sends key words with live calendar time, predicts the mode, cursors, edit
// buffer, commit event and alarm enable after each key, and checks every
// result word field by field. A short directed table comes first, then a
// random part weighted towards editing sequences, with bursty input, random
// output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import ctse_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RANDOM_ITEMS    = 1900;
  localparam int HOLD_CYCLES     = 48;
  localparam int DRAIN_LIMIT     = 2000;
  localparam int LATENCY_SLACK   = 4;
  localparam int WATCHDOG_CYCLES = 200_000;
  localparam int MAX_REPORTS     = 40;
  localparam int NUM_DIRECTED    = 25;
  localparam int NUM_FIELDS      = 11;

  // Key code the package leaves unnamed
  localparam logic [2:0] KEY_SPARE = 3'd7;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] wday;
  } live_time_t;

  typedef struct packed {
    logic [2:0] key;
    live_time_t live;
  } key_word_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] cursor;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] wday;
    logic [1:0] ev;
    logic       alarm;
  } editor_view_t;

  typedef struct packed {
    logic [2:0]   key;
    live_time_t   live;
    logic         typed;
    editor_view_t view;
  } step_row_t;

  localparam logic PREDICTED = 1'b0;
  localparam logic TYPED     = 1'b1;

  localparam live_time_t LIVE_MID  = {7'd24, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30, 3'd4};
  localparam live_time_t LIVE_ONES = '1;
  localparam live_time_t LIVE_NO_MONTH = {7'd0, 4'd0, 5'd31, 5'd0, 6'd0, 6'd0, 3'd0};

  localparam editor_view_t VIEW_ZERO  = '0;
  localparam editor_view_t VIEW_ALARM = {MODE_CODE_SHOW, FLD_YEAR, 7'd0, 4'd0, 5'd0,
                                         5'd0, 6'd0, 6'd0, 3'd0, EV_NONE, 1'b1};
  localparam editor_view_t VIEW_LOAD_ONES = {MODE_CODE_TIME, FLD_YEAR, 7'd127, 4'd15, 5'd31,
                                             5'd31, 6'd63, 6'd63, 3'd7, EV_NONE, 1'b1};
  localparam editor_view_t VIEW_LOAD_NO_MONTH = {MODE_CODE_TIME, FLD_YEAR, 7'd0, 4'd0, 5'd31,
                                                 5'd0, 6'd0, 6'd0, 3'd0, EV_NONE, 1'b0};

  // Directed sequence: keys in show mode, loading extremes, wraps both ways,
  // both commits, the alarm toggle and a month outside the calendar
  step_row_t directed_steps [NUM_DIRECTED] = '{
    {KEY_NONE,   LIVE_MID,      TYPED,     VIEW_ZERO},
    {KEY_SPARE,  LIVE_ONES,     TYPED,     VIEW_ZERO},
    {KEY_NEXT,   LIVE_MID,      TYPED,     VIEW_ZERO},
    {KEY_UP,     LIVE_MID,      TYPED,     VIEW_ZERO},
    {KEY_DOWN,   LIVE_MID,      TYPED,     VIEW_ZERO},
    {KEY_COMMIT, LIVE_MID,      TYPED,     VIEW_ZERO},
    {KEY_ALARM,  LIVE_MID,      TYPED,     VIEW_ALARM},
    {KEY_MODE,   LIVE_ONES,     TYPED,     VIEW_LOAD_ONES},
    {KEY_DOWN,   LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_UP,     LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_DOWN,   LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_COMMIT, LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_MODE,   LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_DOWN,   LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_NEXT,   LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_UP,     LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_COMMIT, LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_ALARM,  LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_MODE,   LIVE_NO_MONTH, TYPED,     VIEW_LOAD_NO_MONTH},
    {KEY_NEXT,   LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_NEXT,   LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_UP,     LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_DOWN,   LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_MODE,   LIVE_MID,      PREDICTED, VIEW_ZERO},
    {KEY_MODE,   LIVE_MID,      PREDICTED, VIEW_ZERO}
  };

  string field_names [NUM_FIELDS] = '{"mode", "cursor", "edit_year", "edit_month",
    "edit_day", "edit_hour", "edit_minute", "edit_second", "edit_weekday",
    "event_res", "alarm_on"};

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] key_code_i;
  logic [6:0] live_year_i;
  logic [3:0] live_month_i;
  logic [4:0] live_day_i;
  logic [4:0] live_hour_i;
  logic [5:0] live_minute_i;
  logic [5:0] live_second_i;
  logic [2:0] live_weekday_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] mode_o;
  logic [2:0] cursor_o;
  logic [6:0] edit_year_o;
  logic [3:0] edit_month_o;
  logic [4:0] edit_day_o;
  logic [4:0] edit_hour_o;
  logic [5:0] edit_minute_o;
  logic [5:0] edit_second_o;
  logic [2:0] edit_weekday_o;
  logic [1:0] event_res_o;
  logic       alarm_on_o;

  // Editor state as the predictor sees it
  logic [1:0]  cur_mode;
  logic [2:0]  time_cur;
  logic        alarm_cur;
  int unsigned edit_buf [7];
  logic        alarm_en;

  editor_view_t expected_views [$];
  int unsigned  err_count;
  int unsigned  words_sent;
  int unsigned  effective_words;
  int unsigned  results_checked;
  int unsigned  commits_seen;
  int unsigned  input_held;
  int unsigned  burst_left;
  logic         hold_req;
  logic         hold_done;

  clock_time_setting_editor_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .key_code_i     (key_code_i),
    .live_year_i    (live_year_i),
    .live_month_i   (live_month_i),
    .live_day_i     (live_day_i),
    .live_hour_i    (live_hour_i),
    .live_minute_i  (live_minute_i),
    .live_second_i  (live_second_i),
    .live_weekday_i (live_weekday_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mode_o         (mode_o),
    .cursor_o       (cursor_o),
    .edit_year_o    (edit_year_o),
    .edit_month_o   (edit_month_o),
    .edit_day_o     (edit_day_o),
    .edit_hour_o    (edit_hour_o),
    .edit_minute_o  (edit_minute_o),
    .edit_second_o  (edit_second_o),
    .edit_weekday_o (edit_weekday_o),
    .event_res_o    (event_res_o),
    .alarm_on_o     (alarm_on_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Days in a month, zero outside the calendar; every fourth year is leap
  function automatic int unsigned days_in(input int unsigned month, input int unsigned year);
    case (month)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return (year % 4 == 0) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Apply one key to the predicted state and return the view after it
  function automatic editor_view_t apply_key(input key_word_t w);
    editor_view_t v;
    logic [2:0]   sel;
    int unsigned  len;
    logic         day_under;
    logic [1:0]   ev;
    ev = EV_NONE;
    day_under = 1'b0;
    case (w.key)
      KEY_MODE: begin
        if (cur_mode == MODE_CODE_SHOW) begin
          edit_buf[FLD_YEAR]   = w.live.year;
          edit_buf[FLD_MONTH]  = w.live.month;
          edit_buf[FLD_DAY]    = w.live.day;
          edit_buf[FLD_HOUR]   = w.live.hour;
          edit_buf[FLD_MINUTE] = w.live.minute;
          edit_buf[FLD_SECOND] = w.live.second;
          edit_buf[FLD_WDAY]   = w.live.wday;
          cur_mode = MODE_CODE_TIME;
          time_cur = FLD_YEAR;
        end else if (cur_mode == MODE_CODE_TIME) begin
          cur_mode = MODE_CODE_ALARM;
        end else begin
          cur_mode = MODE_CODE_SHOW;
        end
      end
      KEY_COMMIT: begin
        if (cur_mode == MODE_CODE_TIME) begin
          ev = EV_TIME;
        end else if (cur_mode == MODE_CODE_ALARM) begin
          ev = EV_ALARM;
          cur_mode = MODE_CODE_SHOW;
        end
      end
      KEY_ALARM: alarm_en = ~alarm_en;
      KEY_NEXT, KEY_UP, KEY_DOWN: begin
        if (cur_mode == MODE_CODE_TIME) begin
          sel = time_cur;
          if (w.key == KEY_NEXT) begin
            time_cur = (time_cur == FLD_WDAY) ? FLD_YEAR : time_cur + 3'd1;
          end else if (w.key == KEY_UP) begin
            // Advance the field, then wrap every field
            edit_buf[sel] += 1;
            if (edit_buf[FLD_YEAR] > YEAR_MAX) edit_buf[FLD_YEAR] = 0;
            if (edit_buf[FLD_MONTH] > MONTH_MAX) edit_buf[FLD_MONTH] = 1;
            len = days_in(edit_buf[FLD_MONTH], edit_buf[FLD_YEAR]);
            if (len != 0 && edit_buf[FLD_DAY] > len) edit_buf[FLD_DAY] = 1;
            if (edit_buf[FLD_HOUR] > HOUR_MAX) edit_buf[FLD_HOUR] = 0;
            if (edit_buf[FLD_MINUTE] > MINUTE_MAX) edit_buf[FLD_MINUTE] = 0;
            if (edit_buf[FLD_SECOND] > MINUTE_MAX) edit_buf[FLD_SECOND] = 0;
            if (edit_buf[FLD_WDAY] > WDAY_MAX) edit_buf[FLD_WDAY] = 1;
          end else begin
            // Step back; a zero field goes to its top, a zero day waits for the month
            if (edit_buf[sel] == 0) begin
              case (sel)
                FLD_YEAR:   edit_buf[sel] = YEAR_MAX;
                FLD_MONTH:  edit_buf[sel] = MONTH_MAX;
                FLD_DAY:    day_under = 1'b1;
                FLD_HOUR:   edit_buf[sel] = HOUR_MAX;
                FLD_WDAY:   edit_buf[sel] = WDAY_MAX;
                default:    edit_buf[sel] = MINUTE_MAX;
              endcase
            end else begin
              edit_buf[sel] -= 1;
            end
            if (edit_buf[FLD_MONTH] == 0) edit_buf[FLD_MONTH] = MONTH_MAX;
            len = days_in(edit_buf[FLD_MONTH], edit_buf[FLD_YEAR]);
            if (day_under) begin
              edit_buf[FLD_DAY] = (len != 0) ? len : DAY_MAX;
            end else if (len != 0) begin
              if (edit_buf[FLD_DAY] == 0) edit_buf[FLD_DAY] = len;
              if (edit_buf[FLD_DAY] > len) edit_buf[FLD_DAY] = 1;
            end
            if (edit_buf[FLD_WDAY] == 0) edit_buf[FLD_WDAY] = WDAY_MAX;
          end
        end else if (cur_mode == MODE_CODE_ALARM) begin
          // Alarm edits touch hour and minute only
          sel = FLD_HOUR + 3'(alarm_cur);
          if (w.key == KEY_NEXT) begin
            alarm_cur = ~alarm_cur;
          end else if (w.key == KEY_UP) begin
            edit_buf[sel] += 1;
            if (edit_buf[FLD_HOUR] > HOUR_MAX) edit_buf[FLD_HOUR] = 0;
            if (edit_buf[FLD_MINUTE] > MINUTE_MAX) edit_buf[FLD_MINUTE] = 0;
          end else if (edit_buf[sel] == 0) begin
            edit_buf[sel] = (sel == FLD_HOUR) ? HOUR_MAX : MINUTE_MAX;
          end else begin
            edit_buf[sel] -= 1;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 7; i++) edit_buf[i] &= 'h7F;

    v.mode   = cur_mode;
    v.cursor = (cur_mode == MODE_CODE_ALARM) ? FLD_HOUR + 3'(alarm_cur) : time_cur;
    v.year   = 7'(edit_buf[FLD_YEAR]);
    v.month  = 4'(edit_buf[FLD_MONTH]);
    v.day    = 5'(edit_buf[FLD_DAY]);
    v.hour   = 5'(edit_buf[FLD_HOUR]);
    v.minute = 6'(edit_buf[FLD_MINUTE]);
    v.second = 6'(edit_buf[FLD_SECOND]);
    v.wday   = 3'(edit_buf[FLD_WDAY]);
    v.ev     = ev;
    v.alarm  = alarm_en;
    return v;
  endfunction

  function automatic int unsigned view_field(input editor_view_t v, input int idx);
    case (idx)
      0:       return v.mode;
      1:       return v.cursor;
      2:       return v.year;
      3:       return v.month;
      4:       return v.day;
      5:       return v.hour;
      6:       return v.minute;
      7:       return v.second;
      8:       return v.wday;
      9:       return v.ev;
      default: return v.alarm;
    endcase
  endfunction

  // Random key word, weighted by the current mode so editing runs are long
  function automatic key_word_t random_word();
    key_word_t   w;
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 99);
    if (cur_mode == MODE_CODE_SHOW) begin
      if (r < 55)      w.key = KEY_MODE;
      else if (r < 65) w.key = KEY_ALARM;
      else if (r < 75) w.key = $urandom_range(0, 1) ? KEY_SPARE : KEY_NONE;
      else             w.key = 3'($urandom_range(KEY_NEXT, KEY_COMMIT));
    end else begin
      if (r < 7)       w.key = KEY_MODE;
      else if (r < 14) w.key = KEY_COMMIT;
      else if (r < 34) w.key = KEY_NEXT;
      else if (r < 64) w.key = KEY_UP;
      else if (r < 93) w.key = KEY_DOWN;
      else if (r < 96) w.key = KEY_ALARM;
      else             w.key = $urandom_range(0, 1) ? KEY_SPARE : KEY_NONE;
    end
    if ($urandom_range(0, 9) == 0) begin
      // Raw bits, out-of-calendar values included
      w.live.year   = 7'($urandom);
      w.live.month  = 4'($urandom);
      w.live.day    = 5'($urandom);
      w.live.hour   = 5'($urandom);
      w.live.minute = 6'($urandom);
      w.live.second = 6'($urandom);
      w.live.wday   = 3'($urandom);
    end else begin
      w.live.year   = 7'($urandom_range(0, YEAR_MAX));
      w.live.month  = 4'($urandom_range(1, MONTH_MAX));
      len = days_in(w.live.month, w.live.year);
      case ($urandom_range(0, 3))
        0:       w.live.day = 5'd1;
        1:       w.live.day = 5'(len);
        2:       w.live.day = 5'(len - 1);
        default: w.live.day = 5'($urandom_range(1, DAY_MAX));
      endcase
      w.live.hour   = 5'($urandom_range(0, HOUR_MAX));
      w.live.minute = 6'($urandom_range(0, MINUTE_MAX));
      w.live.second = 6'($urandom_range(0, MINUTE_MAX));
      w.live.wday   = 3'($urandom_range(1, WDAY_MAX));
    end
    return w;
  endfunction

  // Offer one word and hold it until it is taken
  task automatic send_word(input key_word_t w);
    key_code_i     <= w.key;
    live_year_i    <= w.live.year;
    live_month_i   <= w.live.month;
    live_day_i     <= w.live.day;
    live_hour_i    <= w.live.hour;
    live_minute_i  <= w.live.minute;
    live_second_i  <= w.live.second;
    live_weekday_i <= w.live.wday;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Bursts of back-to-back words with idle gaps between them
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      if (!(hold_req && !hold_done)) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  // Stimulus and end of run
  initial begin
    key_word_t    w;
    step_row_t    row;
    editor_view_t predicted;
    int unsigned  drain;
    in_valid_i     <= 1'b0;
    key_code_i     <= KEY_NONE;
    live_year_i    <= '0;
    live_month_i   <= '0;
    live_day_i     <= '0;
    live_hour_i    <= '0;
    live_minute_i  <= '0;
    live_second_i  <= '0;
    live_weekday_i <= '0;
    rst_ni         <= 1'b0;
    cur_mode  = MODE_CODE_SHOW;
    time_cur  = FLD_YEAR;
    alarm_cur = 1'b0;
    alarm_en  = 1'b0;
    for (int i = 0; i < 7; i++) edit_buf[i] = 0;
    err_count = 0;
    words_sent = 0;
    effective_words = 0;
    burst_left = 0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_steps[i];
      w = {row.key, row.live};
      send_word(w);
      predicted = apply_key(w);
      expected_views.push_back(row.typed ? row.view : predicted);
      words_sent++;
      pace();
    end

    // Random part; the long output hold-off lands at its start
    hold_req = 1'b1;
    while (effective_words < RANDOM_ITEMS) begin
      w = random_word();
      if (w.key == KEY_MODE || w.key == KEY_ALARM ||
          (cur_mode != MODE_CODE_SHOW && w.key inside {KEY_NEXT, KEY_UP, KEY_DOWN, KEY_COMMIT}))
        effective_words++;
      send_word(w);
      expected_views.push_back(apply_key(w));
      words_sent++;
      pace();
    end
    in_valid_i <= 1'b0;

    // Drain, then allow for stray results
    drain = 0;
    while (expected_views.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (LATENCY_SLACK) @(posedge clk_i);
    if (expected_views.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_views.size());
    end

    $display("tb_top: %0d key words sent (%0d directed, %0d with effect in the random part)",
             words_sent, NUM_DIRECTED, effective_words);
    $display("tb_top: %0d results checked, %0d commits, input held back %0d cycles, %0d errors",
             results_checked, commits_seen, input_held, err_count);
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Receiver: stall style rotates through four styles, plus one long hold-off
  initial begin
    int unsigned cyc;
    int unsigned style;
    out_stall_i <= 1'b0;
    hold_done = 1'b0;
    cyc = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        style = (cyc / 150) % 4;
        case (style)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 9) < 3);
          2:       out_stall_i <= ((cyc % 5) < 2);
          default: out_stall_i <= ($urandom_range(0, 9) < 7);
        endcase
        cyc++;
      end
    end
  end

  // Check each result word against the oldest expectation
  always @(posedge clk_i) begin : result_check
    editor_view_t got;
    editor_view_t want;
    if (rst_ni && in_valid_i && in_stall_o) input_held++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {mode_o, cursor_o, edit_year_o, edit_month_o, edit_day_o, edit_hour_o,
             edit_minute_o, edit_second_o, edit_weekday_o, event_res_o, alarm_on_o};
      if (expected_views.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: result word with nothing expected, mode %0d", $time, mode_o);
      end else begin
        want = expected_views.pop_front();
        results_checked++;
        if (got.ev != EV_NONE) commits_seen++;
        for (int i = 0; i < NUM_FIELDS; i++) begin
          if (view_field(want, i) != view_field(got, i)) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: result %0d %s expected %0d actual %0d", $time, results_checked,
                       field_names[i], view_field(want, i), view_field(got, i));
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
